FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL. Each use sits on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("%m: assertion failed");

// The consequence holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// The consequence holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

FILE: rtl/core/srtf_pkg.sv
package srtf_pkg;

   localparam int DATA_W        = 16;
   localparam int TIME_W        = 21;
   localparam int ID_W          = 5;
   localparam int MAX_PROCS_DEF = 16;

   typedef struct packed {
      logic [DATA_W-1:0] arrival;
      logic [DATA_W-1:0] burst;
      logic [DATA_W-1:0] remaining;
   } entry_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_STEP,
      ST_EMIT
   } state_type;

endpackage

FILE: rtl/core/srtf_scheduler_sim.sv
// Preemptive shortest-remaining-time-first scheduler.
// The req channel loads one job per transfer (arrival tick, burst length);
// ids follow load order from 1. Jobs beyond MAX_PROCS are dropped. A transfer
// with req_last set loads its job (if there is room) and starts the run; req_stall
// stays high until the last completion of the run sits in the output register.
// The block loads one job per cycle. During the run every scheduling step reads
// the whole job table through the single read port of the table memory: a scan
// over all n loaded jobs, then the step itself in ST_STEP, and ST_EMIT when a
// job completes. A run has at most 2n steps (one per arrival and one per
// completion).
// Each completion appears on the rsp channel with job id, completion tick,
// turnaround and waiting time; rsp_final_result marks the last one of a run.
// A result waits in an output register while rsp_stall is high; the run
// pauses before loading the next completion until the register is free.
// After the final completion the block accepts a new set at once.
// Reset empties the job set and clears the pending result; the table memory
// needs no clearing since only loaded entries are read.
module srtf_scheduler_sim #(
   parameter int MAX_PROCS = srtf_pkg::MAX_PROCS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [srtf_pkg::DATA_W-1:0]   req_arrival,
   input  logic [srtf_pkg::DATA_W-1:0]   req_burst,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [srtf_pkg::ID_W-1:0]     rsp_job_id,
   output logic [srtf_pkg::TIME_W-1:0]   rsp_completion_time,
   output logic [srtf_pkg::TIME_W-1:0]   rsp_turnaround,
   output logic [srtf_pkg::TIME_W-1:0]   rsp_waiting,
   output logic                          rsp_final_result
);
   import srtf_pkg::*;
   `include "assert_macros.svh"

   localparam int IW  = $clog2(MAX_PROCS);
   localparam int CW  = $clog2(MAX_PROCS + 1);
   localparam int TW  = $clog2((MAX_PROCS + 1) * (1 << DATA_W));
   localparam int NW  = (TW > TIME_W) ? TW : TIME_W;
   localparam int IDW = (CW > ID_W) ? CW : ID_W;

   state_type             state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         left_ff, left_in;
   logic [NW-1:0]         now_ff, now_in;
   logic [MAX_PROCS-1:0]  finished_ff, finished_in;
   logic [CW-1:0]         scan_ff, scan_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [IW-1:0]         rd_idx_ff, rd_idx_in;
   logic                  have_best_ff, have_best_in;
   logic [IW-1:0]         best_idx_ff, best_idx_in;
   entry_type             best_ent_ff, best_ent_in;
   logic                  have_next_ff, have_next_in;
   logic [DATA_W-1:0]     next_ff, next_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]       rsp_job_id_ff, rsp_job_id_in;
   logic [TIME_W-1:0]     rsp_completion_ff, rsp_completion_in;
   logic [TIME_W-1:0]     rsp_turnaround_ff, rsp_turnaround_in;
   logic [TIME_W-1:0]     rsp_waiting_ff, rsp_waiting_in;
   logic                  rsp_final_ff, rsp_final_in;

   logic                  wr_en;
   logic [IW-1:0]         wr_addr;
   entry_type             wr_data;
   logic                  rd_en;
   logic [IW-1:0]         rd_addr;
   entry_type             rd_data;

   logic                  req_xfer;
   logic                  rsp_hold;
   logic                  issue;
   logic [DATA_W-1:0]     burst_fix;
   logic [CW-1:0]         count_next;
   logic [NW-1:0]         gap;
   logic [DATA_W-1:0]     run_len;
   logic [DATA_W-1:0]     rem_next;
   logic [NW-1:0]         tat;
   logic [NW-1:0]         wait_time;
   logic [IDW-1:0]        id_wide;

   srtf_table #(
      .DEPTH (MAX_PROCS),
      .AW    (IW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != ST_LOAD);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_hold  = rsp_valid_ff && rsp_stall;
   assign issue     = (state_ff == ST_SCAN) && (scan_ff < count_ff);
   assign burst_fix = (req_burst == '0) ? DATA_W'(1) : req_burst;

   assign gap      = NW'(next_ff) - now_ff;
   assign run_len  = (have_next_ff && (gap < NW'(best_ent_ff.remaining))) ?
                     gap[DATA_W-1:0] : best_ent_ff.remaining;
   assign rem_next = best_ent_ff.remaining - run_len;

   assign tat       = now_ff - NW'(best_ent_ff.arrival);
   assign wait_time = tat - NW'(best_ent_ff.burst);
   assign id_wide   = IDW'(best_idx_ff) + IDW'(1);

   assign rd_en   = issue;
   assign rd_addr = scan_ff[IW-1:0];

   always_comb begin
      state_in          = state_ff;
      count_in          = count_ff;
      left_in           = left_ff;
      now_in            = now_ff;
      finished_in       = finished_ff;
      scan_in           = scan_ff;
      rd_vld_in         = issue;
      rd_idx_in         = scan_ff[IW-1:0];
      have_best_in      = have_best_ff;
      best_idx_in       = best_idx_ff;
      best_ent_in       = best_ent_ff;
      have_next_in      = have_next_ff;
      next_in           = next_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_job_id_in     = rsp_job_id_ff;
      rsp_completion_in = rsp_completion_ff;
      rsp_turnaround_in = rsp_turnaround_ff;
      rsp_waiting_in    = rsp_waiting_ff;
      rsp_final_in      = rsp_final_ff;
      wr_en             = 1'b0;
      wr_addr           = count_ff[IW-1:0];
      wr_data           = '{arrival: req_arrival, burst: burst_fix, remaining: burst_fix};
      count_next        = count_ff;

      case (state_ff)
         ST_LOAD: begin
            if (req_xfer) begin
               if (count_ff < CW'(MAX_PROCS)) begin
                  wr_en      = 1'b1;
                  count_next = count_ff + CW'(1);
               end
               count_in = count_next;
               if (req_last) begin
                  left_in      = count_next;
                  scan_in      = '0;
                  have_best_in = 1'b0;
                  have_next_in = 1'b0;
                  state_in     = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (issue) begin
               scan_in = scan_ff + CW'(1);
            end
            // Entry data arrives in the cycle after its read was issued.
            if (rd_vld_ff && !finished_ff[rd_idx_ff]) begin
               if (NW'(rd_data.arrival) <= now_ff) begin
                  if (!have_best_ff ||
                      (rd_data.remaining < best_ent_ff.remaining) ||
                      ((rd_data.remaining == best_ent_ff.remaining) &&
                       (rd_data.arrival < best_ent_ff.arrival))) begin
                     have_best_in = 1'b1;
                     best_idx_in  = rd_idx_ff;
                     best_ent_in  = rd_data;
                  end
               end else if (!have_next_ff || (rd_data.arrival < next_ff)) begin
                  have_next_in = 1'b1;
                  next_in      = rd_data.arrival;
               end
            end
            if (!issue && !rd_vld_ff) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            scan_in      = '0;
            have_best_in = 1'b0;
            have_next_in = 1'b0;
            if (!have_best_ff) begin
               // No unfinished job has arrived yet, so time jumps to the next arrival.
               now_in   = NW'(next_ff);
               state_in = ST_SCAN;
            end else begin
               // The chosen job runs until it ends or another job arrives.
               wr_en                 = 1'b1;
               wr_addr               = best_idx_ff;
               wr_data               = best_ent_ff;
               wr_data.remaining     = rem_next;
               best_ent_in.remaining = rem_next;
               now_in                = now_ff + NW'(run_len);
               if (rem_next == '0) begin
                  finished_in[best_idx_ff] = 1'b1;
                  have_best_in             = 1'b1;
                  state_in                 = ST_EMIT;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_hold) begin
               rsp_valid_in      = 1'b1;
               rsp_job_id_in     = id_wide[ID_W-1:0];
               rsp_completion_in = now_ff[TIME_W-1:0];
               rsp_turnaround_in = tat[TIME_W-1:0];
               rsp_waiting_in    = wait_time[TIME_W-1:0];
               rsp_final_in      = (left_ff == CW'(1));
               left_in           = left_ff - CW'(1);
               have_best_in      = 1'b0;
               if (left_ff == CW'(1)) begin
                  finished_in = '0;
                  count_in    = '0;
                  now_in      = '0;
                  state_in    = ST_LOAD;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         left_ff      <= '0;
         now_ff       <= '0;
         finished_ff  <= '0;
         scan_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         have_best_ff <= 1'b0;
         have_next_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         left_ff      <= left_in;
         now_ff       <= now_in;
         finished_ff  <= finished_in;
         scan_ff      <= scan_in;
         rd_vld_ff    <= rd_vld_in;
         have_best_ff <= have_best_in;
         have_next_ff <= have_next_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff         <= rd_idx_in;
      best_idx_ff       <= best_idx_in;
      best_ent_ff       <= best_ent_in;
      next_ff           <= next_in;
      rsp_job_id_ff     <= rsp_job_id_in;
      rsp_completion_ff <= rsp_completion_in;
      rsp_turnaround_ff <= rsp_turnaround_in;
      rsp_waiting_ff    <= rsp_waiting_in;
      rsp_final_ff      <= rsp_final_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_job_id          = rsp_job_id_ff;
   assign rsp_completion_time = rsp_completion_ff;
   assign rsp_turnaround      = rsp_turnaround_ff;
   assign rsp_waiting         = rsp_waiting_ff;
   assign rsp_final_result    = rsp_final_ff;

   `ASSERT_ALWAYS(a_left_le_count, clock, reset, left_ff <= count_ff)
   `ASSERT_ALWAYS(a_scan_le_count, clock, reset, scan_ff <= count_ff)
   `ASSERT_IMPLIES(a_finished_track, clock, reset, state_ff == ST_SCAN, $countones(finished_ff) == int'(count_ff) - int'(left_ff))
   `ASSERT_NEXT(a_emit_loads_rsp, clock, reset, state_ff == ST_EMIT && !rsp_hold, rsp_valid_ff)

endmodule

FILE: rtl/core/srtf_table.sv
module srtf_table #(
   parameter int DEPTH = srtf_pkg::MAX_PROCS_DEF,
   parameter int AW    = $clog2(srtf_pkg::MAX_PROCS_DEF)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  srtf_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output srtf_pkg::entry_type rd_data
);
   import srtf_pkg::*;

   entry_type entries_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entries_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sim/tb_srtf_scheduler_sim.sv
`timescale 1ns / 1ps

module tb_srtf_scheduler_sim;
   import srtf_pkg::*;

   localparam int MAX_JOBS      = MAX_PROCS_DEF;
   localparam int TARGET_JOBS   = 310;
   localparam int HOLD_SET      = 4;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 100;

   typedef enum {MIX_TIGHT, MIX_SPREAD, MIX_WIDE, MIX_LATE} job_mix_type;

   typedef struct {
      logic [DATA_W-1:0] arrival;
      logic [DATA_W-1:0] burst;
      logic              last;
      int                gap;
      bit                drain;
   } job_item_type;

   typedef struct packed {
      logic [ID_W-1:0]   job_id;
      logic [TIME_W-1:0] completion_time;
      logic [TIME_W-1:0] turnaround;
      logic [TIME_W-1:0] waiting;
      logic              final_result;
   } completion_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [DATA_W-1:0] req_arrival = '0;
   logic [DATA_W-1:0] req_burst = '0;
   logic              req_last = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [ID_W-1:0]   rsp_job_id;
   logic [TIME_W-1:0] rsp_completion_time;
   logic [TIME_W-1:0] rsp_turnaround;
   logic [TIME_W-1:0] rsp_waiting;
   logic              rsp_final_result;

   srtf_scheduler_sim uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_arrival         (req_arrival),
      .req_burst           (req_burst),
      .req_last            (req_last),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_job_id          (rsp_job_id),
      .rsp_completion_time (rsp_completion_time),
      .rsp_turnaround      (rsp_turnaround),
      .rsp_waiting         (rsp_waiting),
      .rsp_final_result    (rsp_final_result)
   );

   always #5 clock = ~clock;

   // Scheduler state mirrored by the predictor.
   logic [DATA_W-1:0] arr_tab  [MAX_JOBS];
   logic [DATA_W-1:0] len_tab  [MAX_JOBS];
   logic [DATA_W-1:0] left_tab [MAX_JOBS];
   bit                done_tab [MAX_JOBS];
   int                held_jobs = 0;

   job_item_type   job_queue[$];
   completion_type pending_completions[$];

   int  errors = 0;
   int  jobs_taken = 0;
   int  jobs_dropped = 0;
   int  sets_run = 0;
   int  completions_seen = 0;
   int  total_jobs = 0;
   bit  req_fire = 1'b0;
   bit  rsp_fire = 1'b0;
   bit  last_was_final = 1'b0;
   int  send_gap = 0;
   int  stall_left = 0;
   bit  rsp_quiet = 1'b0;
   int  sets_offered = 0;
   int  hold_left = 0;

   function automatic bit serves_first(int a, int b);
      if (left_tab[a] != left_tab[b]) return left_tab[a] < left_tab[b];
      if (arr_tab[a] != arr_tab[b]) return arr_tab[a] < arr_tab[b];
      return a < b;
   endfunction

   // Plays the whole set from tick zero and queues every completion in order.
   function automatic void run_schedule();
      logic [TIME_W-1:0] tick;
      logic [TIME_W-1:0] next_arrival;
      logic [TIME_W-1:0] span;
      int                unfinished;
      int                pick;
      bit                found;
      bit                later;
      completion_type    done;
      tick = '0;
      unfinished = held_jobs;
      while (unfinished > 0) begin
         found = 1'b0;
         later = 1'b0;
         pick = 0;
         next_arrival = '0;
         for (int i = 0; i < held_jobs; i++) begin
            if (!done_tab[i]) begin
               if (arr_tab[i] <= tick) begin
                  if (!found || serves_first(i, pick)) begin
                     pick = i;
                     found = 1'b1;
                  end
               end else if (!later || arr_tab[i] < next_arrival) begin
                  next_arrival = TIME_W'(arr_tab[i]);
                  later = 1'b1;
               end
            end
         end
         if (!found) begin
            tick = next_arrival;
         end else begin
            // The chosen job runs until it ends or the next job arrives.
            span = TIME_W'(left_tab[pick]);
            if (later && next_arrival - tick < span) span = next_arrival - tick;
            left_tab[pick] = DATA_W'(left_tab[pick] - span);
            tick = tick + span;
            if (left_tab[pick] == 0) begin
               done_tab[pick] = 1'b1;
               unfinished--;
               done.job_id = ID_W'(pick + 1);
               done.completion_time = tick;
               done.turnaround = tick - arr_tab[pick];
               done.waiting = done.turnaround - len_tab[pick];
               done.final_result = (unfinished == 0);
               pending_completions.push_back(done);
            end
         end
      end
      for (int i = 0; i < MAX_JOBS; i++) done_tab[i] = 1'b0;
      held_jobs = 0;
   endfunction

   function automatic void load_job(logic [DATA_W-1:0] arrival, logic [DATA_W-1:0] burst,
                                    logic last);
      logic [DATA_W-1:0] service;
      service = (burst == 0) ? DATA_W'(1) : burst;
      if (held_jobs < MAX_JOBS) begin
         arr_tab[held_jobs] = arrival;
         len_tab[held_jobs] = service;
         left_tab[held_jobs] = service;
         done_tab[held_jobs] = 1'b0;
         held_jobs++;
      end else begin
         jobs_dropped++;
      end
      if (last) begin
         run_schedule();
         sets_run++;
      end
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   function automatic int pick_gap(bit paced);
      return paced ? int'($urandom_range(0, 13)) : 0;
   endfunction

   function automatic void add_job(int arrival, int burst, bit last, int gap, bit drain);
      job_item_type item;
      item.arrival = DATA_W'(arrival);
      item.burst = DATA_W'(burst);
      item.last = last;
      item.gap = gap;
      item.drain = drain;
      job_queue.push_back(item);
   endfunction

   always @(posedge clock) begin : monitor
      completion_type want;
      req_fire = !reset && req_valid && !req_stall;
      rsp_fire = !reset && rsp_valid && !rsp_stall;
      if (req_fire) begin
         jobs_taken++;
         load_job(req_arrival, req_burst, req_last);
      end
      if (rsp_fire) begin
         completions_seen++;
         last_was_final = rsp_final_result;
         if (pending_completions.size() == 0) begin
            errors++;
            $display("%0t: unexpected completion, job %0d at tick %0d", $time,
                     rsp_job_id, rsp_completion_time);
         end else begin
            want = pending_completions.pop_front();
            check_field("job_id", want.job_id, rsp_job_id);
            check_field("completion_time", want.completion_time, rsp_completion_time);
            check_field("turnaround", want.turnaround, rsp_turnaround);
            check_field("waiting", want.waiting, rsp_waiting);
            check_field("final_result", want.final_result, rsp_final_result);
         end
      end
   end

   always @(negedge clock) begin : driver
      job_item_type item;
      bit           offer;
      offer = req_valid;
      if (!reset) begin
         if (req_valid && req_fire) begin
            offer = 1'b0;
            send_gap = (job_queue.size() > 0) ? job_queue[0].gap : 0;
         end
         if (!offer) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (job_queue.size() > 0 &&
                         !(job_queue[0].drain && pending_completions.size() > 0)) begin
               item = job_queue.pop_front();
               req_arrival <= item.arrival;
               req_burst <= item.burst;
               req_last <= item.last;
               offer = 1'b1;
            end
         end
      end
      req_valid <= offer;
   end

   // Long receiver hold-off once a chosen set has started; the next set keeps knocking.
   always @(posedge clock) begin : hold_off
      if (!reset && req_valid && !req_stall && req_last) sets_offered <= sets_offered + 1;
      if (!reset && req_valid && !req_stall && req_last && sets_offered == HOLD_SET - 1) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(negedge clock) begin : receiver
      if (rsp_fire) begin
         if (last_was_final) rsp_quiet = ($urandom_range(0, 3) == 0);
         stall_left = rsp_quiet ? 0 : int'($urandom_range(0, 13));
      end
      rsp_stall <= !reset && (hold_left != 0 || stall_left != 0);
      if (rsp_valid && stall_left != 0) stall_left--;
   end

   initial begin : stimulus
      job_mix_type       mix;
      int                set_size;
      bit                paced;
      bit                drain;
      logic [DATA_W-1:0] arr;
      logic [DATA_W-1:0] bur;

      add_job(0, 1, 1'b1, 0, 1'b0);
      // Idle all the way to the latest arrival, then the longest burst.
      add_job(16'hFFFF, 16'hFFFF, 1'b1, pick_gap(1'b1), 1'b0);
      // A zero burst is served as a single tick.
      add_job(5, 0, 1'b1, pick_gap(1'b1), 1'b0);
      // Preemption, ties on remaining time and arrival, and an idle gap before the last job.
      add_job(0, 8, 1'b0, pick_gap(1'b1), 1'b0);
      add_job(1, 4, 1'b0, pick_gap(1'b1), 1'b0);
      add_job(1, 4, 1'b0, pick_gap(1'b1), 1'b0);
      add_job(2, 3, 1'b0, pick_gap(1'b1), 1'b0);
      add_job(40, 2, 1'b1, pick_gap(1'b1), 1'b0);
      // Overfilled table: the last two jobs are dropped, the final one still starts the run.
      for (int i = 0; i < MAX_JOBS + 2; i++)
         add_job(i * 3, ((i * 7) % 11) + 1, i == MAX_JOBS + 1, pick_gap(i < 8), 1'b0);

      drain = 1'b1;
      while (job_queue.size() < TARGET_JOBS) begin
         set_size = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 19) : $urandom_range(1, 8);
         mix = job_mix_type'($urandom_range(0, 3));
         paced = ($urandom_range(0, 3) != 0);
         for (int k = 0; k < set_size; k++) begin
            case (mix)
               MIX_TIGHT: begin
                  arr = DATA_W'($urandom_range(0, 15));
                  bur = ($urandom_range(0, 19) == 0) ? '0 : DATA_W'($urandom_range(1, 12));
               end
               MIX_SPREAD: begin
                  arr = DATA_W'($urandom_range(0, 400));
                  bur = DATA_W'($urandom_range(1, 150));
               end
               MIX_WIDE: begin
                  arr = DATA_W'($urandom);
                  bur = DATA_W'($urandom_range(1, 65535));
               end
               default: begin
                  arr = DATA_W'($urandom_range(65000, 65535));
                  bur = DATA_W'($urandom_range(30000, 65535));
               end
            endcase
            add_job(arr, bur, k == set_size - 1, pick_gap(paced), drain && k == 0);
         end
         drain = ($urandom_range(0, 5) == 0);
      end
      total_jobs = job_queue.size();

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      while (jobs_taken != total_jobs) @(posedge clock);
      while (pending_completions.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Loaded %0d jobs in %0d sets (%0d dropped at a full table), %0d completions checked.",
               total_jobs - jobs_dropped, sets_run, jobs_dropped, completions_seen);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

FILE: srtf_scheduler_sim.f
+incdir+rtl/core
rtl/core/srtf_pkg.sv
rtl/core/srtf_table.sv
rtl/core/srtf_scheduler_sim.sv
sim/tb_srtf_scheduler_sim.sv
